### rtl/core/e2q_pkg.sv
// Shared constants and functions for the zyx Euler-to-quaternion pipeline.
// No dependencies.
`default_nettype none
package e2q_pkg;
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned FracBits    = 30;
  localparam int unsigned Wf          = 60;
  localparam int unsigned RndW        = Wf - FracBits;
  localparam logic signed [63:0] PiW   = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] GainW = 64'sd700114967507363238;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  // arctan(2^-i) at Wf fraction bits; truncated series as the spec gives
  function automatic logic signed [63:0] atan_pow2(input int unsigned i);
    logic signed [63:0] sum;
    logic [63:0]        term;
    int unsigned        e;
    sum = '0;
    if (i == 0) begin
      sum = PiW >>> 2;
    end else begin
      for (int unsigned k = 0; k < 61; k++) begin
        e = i * (2 * k + 1);
        if (e <= Wf) begin
          term = (64'd1 << (Wf - e)) / 64'(2 * k + 1);
          if (k[0]) sum = sum - $signed(term);
          else      sum = sum + $signed(term);
        end
      end
    end
    return sum;
  endfunction

  // round half away from zero by RndW bits
  function automatic logic signed [33:0] rnd_sc(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (RndW - 1))) >> RndW;
    return v[63] ? -34'($signed({1'b0, m[32:0]})) : 34'($signed({1'b0, m[32:0]}));
  endfunction
endpackage
`default_nettype wire

### rtl/core/e2q_mul.sv
// One registered signed FracBits multiply with round half away from zero.
// Depends on e2q_pkg.
`default_nettype none
module e2q_mul (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [33:0] a_i,
  input  wire logic signed [33:0] b_i,
  output logic signed [33:0]      p_o
);
  logic [33:0] ma, mb;
  logic [67:0] pr, rr;
  logic        neg;
  logic signed [33:0] p_d;
  always_comb begin
    neg = a_i[33] ^ b_i[33];
    ma  = a_i[33] ? 34'(-a_i) : 34'(a_i);
    mb  = b_i[33] ? 34'(-b_i) : 34'(b_i);
    pr  = ma * mb;
    rr  = (pr + (68'd1 << (e2q_pkg::FracBits - 1))) >> e2q_pkg::FracBits;
    p_d = neg ? -$signed(rr[33:0]) : $signed(rr[33:0]);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) p_o <= p_d;
  end
endmodule
`default_nettype wire

### rtl/core/euler_to_quaternion_zyx.sv
// Euler angles (x,y,z) to zyx quaternion: CORDIC sin/cos pipeline and products.
// Depends on e2q_pkg and e2q_mul.
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | angle_x[31:0] angle_y[63:32] angle_z[95:64], Q2.29
// m_axis  | out | quat_real quat_first quat_second quat_third, Q1.30 each
//
// One item per cycle while the output is not stalled; one CORDIC stage per step.
// The whole pipe advances together; a stalled output freezes every stage.
// rst_ni clears only the valid bits.
`default_nettype none
module euler_to_quaternion_zyx (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,   // angle_x, angle_y, angle_z
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata    // quat_real, first, second, third
);
  localparam int unsigned NS = e2q_pkg::CordicSteps;
  localparam int unsigned Lat = NS + 5;

  logic adv;
  logic [Lat-1:0] vld_q;
  assign adv = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // stage 0: range reduction
  logic signed [63:0] x_q [3][NS+1];
  logic signed [63:0] y_q [3][NS+1];
  logic signed [63:0] z_q [3][NS+1];
  logic               f_q [3][NS+1];

  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic signed [63:0] z0;
    logic signed [63:0] zr;
    logic               fl;
    always_comb begin
      z0 = 64'($signed(s_axis_tdata[32*a +: 32])) <<< 31;
      fl = 1'b0;
      zr = z0;
      if (z0 > (e2q_pkg::PiW >>> 1)) begin
        zr = z0 - e2q_pkg::PiW; fl = 1'b1;
      end else if (z0 < -(e2q_pkg::PiW >>> 1)) begin
        zr = z0 + e2q_pkg::PiW; fl = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[a][0] <= e2q_pkg::GainW;
        y_q[a][0] <= '0;
        z_q[a][0] <= zr;
        f_q[a][0] <= fl;
      end
    end
    for (genvar i = 0; i < NS; i++) begin : g_st
      localparam logic signed [63:0] At = e2q_pkg::atan_pow2(i);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          f_q[a][i+1] <= f_q[a][i];
          if (!z_q[a][i][63]) begin
            x_q[a][i+1] <= x_q[a][i] - (y_q[a][i] >>> i);
            y_q[a][i+1] <= y_q[a][i] + (x_q[a][i] >>> i);
            z_q[a][i+1] <= z_q[a][i] - At;
          end else begin
            x_q[a][i+1] <= x_q[a][i] + (y_q[a][i] >>> i);
            y_q[a][i+1] <= y_q[a][i] - (x_q[a][i] >>> i);
            z_q[a][i+1] <= z_q[a][i] + At;
          end
        end
      end
    end
  end

  // sin/cos rounding stage
  logic signed [33:0] s_q [3];
  logic signed [33:0] c_q [3];
  for (genvar a = 0; a < 3; a++) begin : g_sc
    logic signed [63:0] xs, ys;
    assign xs = f_q[a][NS] ? -x_q[a][NS] : x_q[a][NS];
    assign ys = f_q[a][NS] ? -y_q[a][NS] : y_q[a][NS];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[a] <= e2q_pkg::rnd_sc(ys);
        c_q[a] <= e2q_pkg::rnd_sc(xs);
      end
    end
  end

  // first products: cxcy sxsy cxsy sxcy; carry z terms
  logic signed [33:0] p1 [4];
  logic signed [33:0] sz_q, cz_q;
  e2q_mul u_m0 (.clk_i, .en_i(adv), .a_i(c_q[0]), .b_i(c_q[1]), .p_o(p1[0]));
  e2q_mul u_m1 (.clk_i, .en_i(adv), .a_i(s_q[0]), .b_i(s_q[1]), .p_o(p1[1]));
  e2q_mul u_m2 (.clk_i, .en_i(adv), .a_i(c_q[0]), .b_i(s_q[1]), .p_o(p1[2]));
  e2q_mul u_m3 (.clk_i, .en_i(adv), .a_i(s_q[0]), .b_i(c_q[1]), .p_o(p1[3]));
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sz_q <= s_q[2];
      cz_q <= c_q[2];
    end
  end

  // second products
  logic signed [33:0] p2 [8];
  e2q_mul u_n0 (.clk_i, .en_i(adv), .a_i(p1[0]), .b_i(cz_q), .p_o(p2[0]));
  e2q_mul u_n1 (.clk_i, .en_i(adv), .a_i(p1[1]), .b_i(sz_q), .p_o(p2[1]));
  e2q_mul u_n2 (.clk_i, .en_i(adv), .a_i(p1[0]), .b_i(sz_q), .p_o(p2[2]));
  e2q_mul u_n3 (.clk_i, .en_i(adv), .a_i(p1[1]), .b_i(cz_q), .p_o(p2[3]));
  e2q_mul u_n4 (.clk_i, .en_i(adv), .a_i(p1[2]), .b_i(cz_q), .p_o(p2[4]));
  e2q_mul u_n5 (.clk_i, .en_i(adv), .a_i(p1[3]), .b_i(sz_q), .p_o(p2[5]));
  e2q_mul u_n6 (.clk_i, .en_i(adv), .a_i(p1[3]), .b_i(cz_q), .p_o(p2[6]));
  e2q_mul u_n7 (.clk_i, .en_i(adv), .a_i(p1[2]), .b_i(sz_q), .p_o(p2[7]));

  // sum and saturate
  logic signed [34:0] sm [4];
  logic [31:0] q_q [4];
  assign sm[0] = 35'(p2[0]) + 35'(p2[1]);
  assign sm[1] = 35'(p2[2]) - 35'(p2[3]);
  assign sm[2] = 35'(p2[4]) + 35'(p2[5]);
  assign sm[3] = 35'(p2[6]) - 35'(p2[7]);
  for (genvar k = 0; k < 4; k++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (sm[k] > 35'(e2q_pkg::OneQ30))       q_q[k] <= e2q_pkg::OneQ30;
        else if (sm[k] < -35'(e2q_pkg::OneQ30)) q_q[k] <= -e2q_pkg::OneQ30;
        else                                    q_q[k] <= sm[k][31:0];
      end
    end
  end
  assign m_axis_tdata = {q_q[3], q_q[2], q_q[1], q_q[0]};

  ap_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  ap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  ap_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[31:0]) <= e2q_pkg::OneQ30 &&
      $signed(m_axis_tdata[31:0]) >= -e2q_pkg::OneQ30)
    else $error("real part out of range");
endmodule
`default_nettype wire
